// File: rtl/assert_macros.svh
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that stays active during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/mfqs_pkg.sv
// package: constants, codes, state type and control structs of the scheduler
package mfqs_pkg;

	localparam int LEVELS_DEF    = 4;
	localparam int MAX_TASKS_DEF = 64;
	localparam int MAX_CPUS_DEF  = 8;
	localparam int RESULT_MAX    = 8;

	localparam int IN_DW   = 16;
	localparam int OUT_DW  = 16;
	localparam int CFG_IW  = 1;
	localparam int CFG_DW  = 4;
	localparam int ID_W    = 6;
	localparam int PRI_W   = 3;
	localparam int SLOT_W  = 3;

	localparam logic [3:0] CPU_COUNT_RST    = 4'd1;
	localparam logic [3:0] RESET_ROUNDS_RST = 4'd3;

	localparam logic [CFG_IW-1:0] CFG_CPU_COUNT    = 1'd0;
	localparam logic [CFG_IW-1:0] CFG_RESET_ROUNDS = 1'd1;

	localparam logic KIND_DISPATCH = 1'b0;
	localparam logic KIND_STATUS   = 1'b1;

	typedef enum logic [1:0] {
		OP_SUBMIT   = 2'd0,
		OP_TICK     = 2'd1,
		OP_EXIT     = 2'd2,
		OP_SHUTDOWN = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DEM,
		ST_DEM2,
		ST_ROUND,
		ST_RW_CHK,
		ST_RW_WR,
		ST_RW_NX,
		ST_SPLICE,
		ST_POP,
		ST_POP2,
		ST_STATUS
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic s_inc;
		logic dem_wr;
		logic slot_clr;
		logic round;
		logic wq_inc;
		logic walk_ld;
		logic walk_wr;
		logic walk_nx;
		logic splice;
		logic pop_wr;
		logic emit_st;
	} cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    s_end;
		logic    live_s;
		logic    rz;
		logic    wq_end;
		logic    hv_w;
		logic    walk_end;
		logic    pop_ok;
		logic    s_zero;
		logic    pop_last;
		logic    out_free;
	} stat_t;

endpackage

// File: rtl/mfqs_ctrl.sv
// control state machine of the scheduler
module mfqs_ctrl import mfqs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   s_tvalid,
	output logic   s_tready,
	input  stat_t  stat,
	output cmd_t   cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_EXEC;
			ST_EXEC:   state_d = (stat.op == OP_TICK) ? ST_DEM : ST_STATUS;
			ST_DEM: begin
				if (stat.s_end) state_d = ST_ROUND;
				else if (stat.live_s) state_d = ST_DEM2;
			end
			ST_DEM2:   state_d = ST_DEM;
			ST_ROUND:  state_d = stat.rz ? ST_RW_CHK : ST_POP;
			ST_RW_CHK: begin
				if (stat.wq_end) state_d = ST_POP;
				else if (stat.hv_w) state_d = ST_RW_WR;
			end
			ST_RW_WR:  state_d = stat.walk_end ? ST_SPLICE : ST_RW_NX;
			ST_RW_NX:  state_d = ST_RW_WR;
			ST_SPLICE: state_d = ST_RW_CHK;
			ST_POP: begin
				if (stat.out_free) begin
					if (stat.pop_ok) state_d = ST_POP2;
					else state_d = stat.s_zero ? ST_STATUS : ST_IDLE;
				end
			end
			ST_POP2:   state_d = stat.pop_last ? ST_IDLE : ST_POP;
			ST_STATUS: if (stat.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// command decode
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_EXEC:   cmd.exec = 1'b1;
			ST_DEM: begin
				if (!stat.s_end && !stat.live_s) begin
					cmd.slot_clr = 1'b1;
					cmd.s_inc    = 1'b1;
				end
			end
			ST_DEM2: begin
				cmd.dem_wr   = 1'b1;
				cmd.slot_clr = 1'b1;
				cmd.s_inc    = 1'b1;
			end
			ST_ROUND:  cmd.round = 1'b1;
			ST_RW_CHK: begin
				if (!stat.wq_end) begin
					cmd.walk_ld = stat.hv_w;
					cmd.wq_inc  = !stat.hv_w;
				end
			end
			ST_RW_WR:  cmd.walk_wr = 1'b1;
			ST_RW_NX:  cmd.walk_nx = 1'b1;
			ST_SPLICE: begin
				cmd.splice = 1'b1;
				cmd.wq_inc = 1'b1;
			end
			ST_POP:    ;
			ST_POP2: begin
				cmd.pop_wr = 1'b1;
				cmd.s_inc  = 1'b1;
			end
			ST_STATUS: cmd.emit_st = stat.out_free;
			default:   ;
		endcase
	end

endmodule

// File: rtl/mfqs_dp.sv
// datapath: queues, task tables, cpu slots and the result register
module mfqs_dp import mfqs_pkg::*; #(
	parameter int LEVELS    = LEVELS_DEF,
	parameter int MAX_TASKS = MAX_TASKS_DEF,
	parameter int MAX_CPUS  = MAX_CPUS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IN_DW-1:0]  s_tdata,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_wdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_DW-1:0] m_tdata,
	output logic              m_tlast,
	output logic [0:0]        m_tuser,
	input  cmd_t              cmd,
	output stat_t             stat
);

	localparam int TW   = $clog2(MAX_TASKS);
	localparam int QW   = $clog2(LEVELS);
	localparam int LVW  = $clog2(LEVELS + 1);
	localparam int SW   = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
	localparam int SCW  = $clog2(MAX_CPUS + 1);
	localparam int NLIM = (MAX_CPUS < RESULT_MAX) ? MAX_CPUS : RESULT_MAX;

	// latched input item and configuration
	opcode_t            op_q;
	logic [ID_W-1:0]    id_q;
	logic [PRI_W-1:0]   pr_q;
	logic [3:0]         cpu_cnt_q;
	logic [3:0]         rst_rounds_q;
	logic [3:0]         rounds_left_q;
	logic               shut_q;

	// sequencing indexes
	logic [SCW-1:0]     s_q;
	logic [LVW-1:0]     wq_q;
	logic [TW-1:0]      walk_t_q;

	// queue heads and tails, per-task and per-slot flags
	logic [TW-1:0]        head_q [LEVELS];
	logic [TW-1:0]        tail_q [LEVELS];
	logic [LEVELS-1:0]    hv_q;
	logic [MAX_TASKS-1:0] queued_q;
	logic [TW-1:0]        slot_task_q [MAX_CPUS];
	logic [MAX_CPUS-1:0]  busy_q;
	logic [MAX_CPUS-1:0]  done_q;

	// task tables
	logic [TW-1:0]  next_link_m [MAX_TASKS];
	logic [LVW-1:0] level_m     [MAX_TASKS];
	logic           started_m   [MAX_TASKS];
	logic [TW-1:0]  nl_rd_q;
	logic [LVW-1:0] lvl_rd_q;
	logic           st_rd_q;

	// result register
	logic              out_v_q;
	logic [OUT_DW-1:0] out_d_q;
	logic              out_l_q;
	logic              out_k_q;

	logic              id_ok, running, sub_ok, do_sub, app_en;
	logic [TW-1:0]     id_t, cur_t, app_t, pop_t;
	logic [LVW-1:0]    pr_lv, lv_inc, app_lv;
	logic [QW-1:0]     aq, pq, wq_idx;
	logic [SW-1:0]     s_idx;
	logic              pop_any, pop_single, rem_any, live_any, fin;
	logic [LEVELS-1:0] pop_clr;
	logic [4:0]        n_lim;
	logic              nl_we, lv_we, st_we, st_wd;
	logic [TW-1:0]     nl_wa, nl_wd, nl_ra, lv_wa, st_wa;
	logic [LVW-1:0]    lv_wd;
	logic              out_free;

	assign s_idx  = s_q[SW-1:0];
	assign wq_idx = wq_q[QW-1:0];
	assign cur_t  = slot_task_q[s_idx];

	// submit checks
	always_comb begin
		id_ok   = 32'(id_q) < MAX_TASKS;
		id_t    = TW'(id_q);
		running = 1'b0;
		for (int s = 0; s < MAX_CPUS; s++) begin
			if (busy_q[s] && !done_q[s] && slot_task_q[s] == id_t) running = 1'b1;
		end
		sub_ok = id_ok && !queued_q[id_t] && !running;
		if (pr_q == '0) pr_lv = LVW'(1);
		else if (32'(pr_q) > LEVELS) pr_lv = LVW'(LEVELS);
		else pr_lv = LVW'(pr_q);
	end

	assign do_sub = cmd.exec && (op_q == OP_SUBMIT) && sub_ok;
	assign lv_inc = (32'(lvl_rd_q) < LEVELS) ? lvl_rd_q + LVW'(1) : lvl_rd_q;

	// append source and target level
	always_comb begin
		app_en = do_sub || cmd.dem_wr;
		app_t  = cmd.dem_wr ? cur_t : id_t;
		app_lv = cmd.dem_wr ? lv_inc : pr_lv;
		if (app_lv == '0 || 32'(app_lv) > LEVELS) aq = QW'(LEVELS - 1);
		else aq = QW'(app_lv - LVW'(1));
	end

	// highest non-empty level for pop
	always_comb begin
		pq      = '0;
		pop_any = 1'b0;
		for (int q = LEVELS - 1; q >= 0; q--) begin
			if (hv_q[q]) begin
				pq      = QW'(q);
				pop_any = 1'b1;
			end
		end
		pop_t      = head_q[pq];
		pop_single = head_q[pq] == tail_q[pq];
		pop_clr    = '0;
		if (pop_single) pop_clr[pq] = 1'b1;
		rem_any    = |(hv_q & ~pop_clr);
		if (cpu_cnt_q == '0) n_lim = 5'd1;
		else if (32'(cpu_cnt_q) > NLIM) n_lim = 5'(NLIM);
		else n_lim = 5'(cpu_cnt_q);
	end

	assign live_any = |(busy_q & ~done_q);
	assign fin      = shut_q && !live_any && !(|hv_q);
	assign out_free = !out_v_q || m_tready;

	// status to the controller
	always_comb begin
		stat.op       = op_q;
		stat.s_end    = 32'(s_q) >= MAX_CPUS;
		stat.live_s   = busy_q[s_idx] && !done_q[s_idx];
		stat.rz       = rounds_left_q == '0;
		stat.wq_end   = 32'(wq_q) >= LEVELS;
		stat.hv_w     = hv_q[wq_idx];
		stat.walk_end = walk_t_q == tail_q[wq_idx];
		stat.pop_ok   = pop_any && (32'(s_q) < 32'(n_lim));
		stat.s_zero   = s_q == '0;
		stat.pop_last = (32'(s_q) + 1 >= 32'(n_lim)) || !rem_any;
		stat.out_free = out_free;
	end

	// table write and read ports
	always_comb begin
		nl_we = (app_en && hv_q[aq]) || (cmd.splice && hv_q[0]);
		nl_wa = cmd.splice ? tail_q[0] : tail_q[aq];
		nl_wd = cmd.splice ? head_q[wq_idx] : app_t;
		nl_ra = cmd.walk_wr ? walk_t_q : pop_t;
		lv_we = app_en || cmd.walk_wr;
		lv_wa = cmd.walk_wr ? walk_t_q : app_t;
		lv_wd = cmd.walk_wr ? LVW'(1) : app_lv;
		st_we = do_sub || cmd.pop_wr;
		st_wa = cmd.pop_wr ? pop_t : id_t;
		st_wd = cmd.pop_wr;
	end

	// task tables
	always_ff @(posedge clk) begin
		if (nl_we) next_link_m[nl_wa] <= nl_wd;
		if (lv_we) level_m[lv_wa] <= lv_wd;
		if (st_we) started_m[st_wa] <= st_wd;
		nl_rd_q  <= next_link_m[nl_ra];
		lvl_rd_q <= level_m[cur_t];
		st_rd_q  <= started_m[pop_t];
	end

	// queue pointers, slot tasks, walk pointer and the latched input item
	always_ff @(posedge clk) begin
		if (app_en) begin
			if (!hv_q[aq]) head_q[aq] <= app_t;
			tail_q[aq] <= app_t;
		end
		if (cmd.splice) begin
			if (!hv_q[0]) head_q[0] <= head_q[wq_idx];
			tail_q[0] <= tail_q[wq_idx];
		end
		if (cmd.pop_wr && !pop_single) head_q[pq] <= nl_rd_q;
		if (cmd.pop_wr) slot_task_q[s_idx] <= pop_t;
		if (cmd.walk_ld) walk_t_q <= head_q[wq_idx];
		if (cmd.walk_nx) walk_t_q <= nl_rd_q;
		if (cmd.accept) begin
			op_q <= opcode_t'(s_tdata[1:0]);
			id_q <= s_tdata[7:2];
			pr_q <= s_tdata[10:8];
		end
	end

	// control state of queues, slots, rounds and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q          <= '0;
			queued_q      <= '0;
			busy_q        <= '0;
			done_q        <= '0;
			s_q           <= '0;
			wq_q          <= '0;
			rounds_left_q <= RESET_ROUNDS_RST;
			shut_q        <= 1'b0;
			cpu_cnt_q     <= CPU_COUNT_RST;
			rst_rounds_q  <= RESET_ROUNDS_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CPU_COUNT:    cpu_cnt_q    <= cfg_wdata;
					CFG_RESET_ROUNDS: rst_rounds_q <= cfg_wdata;
					default:          ;
				endcase
			end
			if (cmd.accept) s_q <= '0;
			if (cmd.s_inc) s_q <= s_q + SCW'(1);
			if (app_en) begin
				hv_q[aq]        <= 1'b1;
				queued_q[app_t] <= 1'b1;
			end
			if (cmd.exec && op_q == OP_EXIT && id_ok) begin
				for (int s = 0; s < MAX_CPUS; s++) begin
					if (busy_q[s] && !done_q[s] && slot_task_q[s] == id_t) done_q[s] <= 1'b1;
				end
			end
			if (cmd.exec && op_q == OP_SHUTDOWN) shut_q <= 1'b1;
			if (cmd.slot_clr) begin
				busy_q[s_idx] <= 1'b0;
				done_q[s_idx] <= 1'b0;
			end
			// round counter and start of the priority reset walk
			if (cmd.round) begin
				s_q  <= '0;
				wq_q <= LVW'(1);
				if (rounds_left_q == '0) rounds_left_q <= rst_rounds_q;
				else rounds_left_q <= rounds_left_q - 4'd1;
			end
			if (cmd.wq_inc) wq_q <= wq_q + LVW'(1);
			if (cmd.splice) begin
				hv_q[0]      <= 1'b1;
				hv_q[wq_idx] <= 1'b0;
			end
			// dispatch of one popped task
			if (cmd.pop_wr) begin
				if (pop_single) hv_q[pq] <= 1'b0;
				queued_q[pop_t] <= 1'b0;
				busy_q[s_idx]   <= 1'b1;
				done_q[s_idx]   <= 1'b0;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.pop_wr || cmd.emit_st) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.pop_wr) begin
			out_d_q <= {5'd0, 1'b0, st_rd_q, ID_W'(pop_t), SLOT_W'(s_q)};
			out_l_q <= stat.pop_last;
			out_k_q <= KIND_DISPATCH;
		end else if (cmd.emit_st) begin
			out_d_q <= {5'd0, fin, 1'b0, ID_W'(0), SLOT_W'(0)};
			out_l_q <= 1'b1;
			out_k_q <= KIND_STATUS;
		end
	end

	assign m_tvalid   = out_v_q;
	assign m_tdata    = out_d_q;
	assign m_tlast    = out_l_q;
	assign m_tuser[0] = out_k_q;

endmodule

// File: rtl/multilevel_feedback_queue_scheduler.sv
// top level: multilevel feedback queue scheduler
// submit, exit and shutdown: execute, then load a status result once the output register is free
// a tick demotes the task of each live slot and frees every slot, steps the round counter, moves all
// tasks to level 1 when a priority reset is due, then dispatches, or gives a status result if none
// one item at a time: the next transfer in is taken once the last result is loaded
// arst_n clears queues, slots and shutdown, sets the round counter to 3 and registers (cpu_count 1, reset_rounds 3)
module multilevel_feedback_queue_scheduler import mfqs_pkg::*; #(
	parameter int LEVELS    = LEVELS_DEF,
	parameter int MAX_TASKS = MAX_TASKS_DEF,
	parameter int MAX_CPUS  = MAX_CPUS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_DW-1:0]  s_tdata,   // opcode[1:0], task_id[7:2], priority_req[10:8]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_DW-1:0] m_tdata,   // cpu_slot[2:0], task_id_res[8:3], resume[9], finished[10]
	output logic              m_tlast,
	output logic [0:0]        m_tuser,   // kind[0]
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	cmd_t  cmd;
	stat_t stat;

	mfqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mfqs_dp #(
		.LEVELS    (LEVELS),
		.MAX_TASKS (MAX_TASKS),
		.MAX_CPUS  (MAX_CPUS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// File: rtl/mfqs_checker.sv
// port checker for the scheduler and its bind
`include "assert_macros.svh"

module mfqs_checker import mfqs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_DW-1:0] m_tdata,
	input logic [0:0]        m_tuser
);

	// a held result stays offered
	`ASSERT_CLK(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

	// one item at a time: no transfer in right after a transfer in
	`ASSERT_CLK(a_one_item, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "input taken while busy")

	// a dispatch leaves a live slot, so it never reports finished
	`ASSERT_CLK(a_disp_fin, clk, arst_n, m_tvalid && m_tuser[0] == KIND_DISPATCH |-> !m_tdata[10], "finished on dispatch")

	// nothing is offered while in reset
	`ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |-> !m_tvalid, "result valid in reset")

endmodule

bind multilevel_feedback_queue_scheduler mfqs_checker u_chk (.*);
